// File: src/sap_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package sap_pkg;

  localparam int COORD_W = 9;
  localparam int PIX_W   = 8;
  localparam int SUM_W   = 17;
  localparam int CNT_W   = 10;
  localparam int PROD_W  = SUM_W + CNT_W;

  typedef enum logic [2:0] {
    OP_WR_PIX  = 3'd0,
    OP_RD_PIX  = 3'd1,
    OP_WR_HOOK = 3'd2,
    OP_PICK    = 3'd3,
    OP_FADE    = 3'd4
  } op_t;

  localparam logic [1:0] CFG_FADE_AMOUNT = 2'd0;
  localparam logic [1:0] CFG_MIN_GAP     = 2'd1;
  localparam logic [1:0] CFG_HOOK_COUNT  = 2'd2;

  localparam logic [7:0] FADE_RESET    = 8'd30;
  localparam logic [7:0] MIN_DIST_RESET = 8'd20;
  localparam logic [8:0] HOOK_CNT_RESET = 9'd200;
  localparam logic [7:0] WHITE          = 8'hFF;

  typedef enum logic [3:0] {
    S_IDLE,
    S_REDUCE,
    S_PIX_RD,
    S_PIX_RESP,
    S_HOOK_A,
    S_HOOK_B,
    S_CAND,
    S_SETUP,
    S_WALK,
    S_ACC,
    S_MUL_A,
    S_MUL_B,
    S_CMP,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
  } line_ctrl_t;

endpackage
`default_nettype wire

// File: src/string_art_line_picker.sv
`timescale 1ns / 1ps
`default_nettype none
// Greedy string-art line picker. Raise start while busy is low to hand in one
// command word; busy stays high until the result word shows on the result
// ports for exactly one cycle with done high, and the receiver must take it
// then. A fade or a pick walks each line pixel by pixel: every pixel is read
// through the single read port of the pixel memory, stepped by one Bresenham
// walker, and each candidate is scored by one shared 17x10 multiplier used
// twice. Unknown opcodes return all zero.
// Configuration may be written only while busy is low.
module string_art_line_picker #(
  parameter int IMG_SIDE  = 512,
  parameter int MAX_HOOKS = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  opcode,
  input  wire logic [8:0]  coord_x,
  input  wire logic [8:0]  coord_y,
  input  wire logic [7:0]  pixel_value,
  input  wire logic [7:0]  hook_index,
  input  wire logic [7:0]  target_hook,
  output logic             done,
  output logic [7:0]       read_value,
  output logic [7:0]       next_hook,
  output logic             found,
  output logic [16:0]      best_sum,
  output logic [9:0]       best_count,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [8:0]  cfg_data
);
  import sap_pkg::*;

  localparam int HW = (MAX_HOOKS > 1) ? $clog2(MAX_HOOKS) : 1;
  localparam int CW = $clog2(MAX_HOOKS + 1);
  localparam int DW = (CW > 9) ? CW + 1 : 10;

  state_t state, state_next;

  logic [7:0] fade_amount;
  logic [7:0] min_gap;
  logic [8:0] hook_count;

  op_t                op_r;
  logic [COORD_W-1:0] x_r, y_r;
  logic [PIX_W-1:0]   val_r;
  logic [7:0]         cur_r, tgt_r;
  logic [CW-1:0]      i_r;
  logic [CW-1:0]      cnt_eff;
  logic               upper;
  logic [DW-1:0]      limit;
  logic [COORD_W-1:0] a_x, a_y;
  logic [SUM_W-1:0]   sum_r, bsum;
  logic [CNT_W-1:0]   n_r, bcnt;
  logic [CW-1:0]      bnext;
  logic               got;
  logic [PROD_W-1:0]  prod_a, prod_b;

  logic [7:0]         res_read;
  logic [7:0]         res_hook;
  logic               res_found;
  logic [SUM_W-1:0]   res_sum;
  logic [CNT_W-1:0]   res_cnt;

  logic [2*COORD_W-1:0] hook_mem [MAX_HOOKS];
  logic [2*COORD_W-1:0] hk_rd;
  logic                 hk_rd_en;
  logic [HW-1:0]        hk_rd_addr;
  logic                 hk_wr_en;

  logic               pm_rd_en, pm_wr_en, pm_rd_in;
  logic [COORD_W-1:0] pm_rd_x, pm_rd_y, pm_wr_x, pm_wr_y;
  logic [PIX_W-1:0]   pm_wr_data, pm_rd_data;
  logic [PIX_W:0]     faded;

  line_ctrl_t         lctrl;
  logic [COORD_W-1:0] pos_x, pos_y;
  logic               at_end;

  logic               reduced;
  logic [DW-1:0]      cur_d, i_d, diff;
  logic               skip;
  logic [SUM_W-1:0]   mul_a;
  logic [CNT_W-1:0]   mul_b;
  logic [PROD_W-1:0]  mul_p;
  logic               accept;

  assign accept    = start && (state == S_IDLE);
  assign busy      = (state != S_IDLE);
  assign done      = (state == S_FINISH);
  assign cfg_ready = 1'b1;

  assign read_value = res_read;
  assign next_hook  = res_hook;
  assign found      = res_found;
  assign best_sum   = res_sum;
  assign best_count = res_cnt;

  assign reduced = !(32'(cur_r) >= MAX_HOOKS) && !(32'(tgt_r) >= MAX_HOOKS);

  assign cur_d = DW'(cur_r);
  assign i_d   = DW'(i_r);
  assign diff  = (cur_d > i_d) ? cur_d - i_d : i_d - cur_d;
  assign skip  = (diff < DW'(min_gap)) || (upper && (diff > limit));

  assign mul_a = (state == S_MUL_A) ? sum_r : bsum;
  assign mul_b = (state == S_MUL_A) ? bcnt : n_r;
  assign mul_p = {{CNT_W{1'b0}}, mul_a} * {{SUM_W{1'b0}}, mul_b};

  assign faded = {1'b0, pm_rd_data} + {1'b0, fade_amount};

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fade_amount <= FADE_RESET;
      min_gap     <= MIN_DIST_RESET;
      hook_count  <= HOOK_CNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_FADE_AMOUNT: fade_amount <= cfg_data[7:0];
        CFG_MIN_GAP:     min_gap     <= cfg_data[7:0];
        CFG_HOOK_COUNT:  hook_count  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    hk_rd_en   = 1'b0;
    hk_rd_addr = HW'(cur_r);
    hk_wr_en   = 1'b0;
    pm_rd_en   = 1'b0;
    pm_rd_x    = x_r;
    pm_rd_y    = y_r;
    pm_wr_en   = 1'b0;
    pm_wr_x    = x_r;
    pm_wr_y    = y_r;
    pm_wr_data = val_r;
    lctrl      = '0;
    unique case (state)
      S_IDLE: begin
        if (start) state_next = S_REDUCE;
      end
      S_REDUCE: begin
        if (reduced) begin
          unique case (op_r)
            OP_WR_PIX: begin
              pm_wr_en   = 1'b1;
              state_next = S_FINISH;
            end
            OP_RD_PIX:  state_next = S_PIX_RD;
            OP_WR_HOOK: begin
              hk_wr_en   = 1'b1;
              state_next = S_FINISH;
            end
            OP_PICK, OP_FADE: state_next = S_HOOK_A;
            default: state_next = S_FINISH;
          endcase
        end
      end
      S_PIX_RD: begin
        pm_rd_en   = 1'b1;
        state_next = S_PIX_RESP;
      end
      S_PIX_RESP: state_next = S_FINISH;
      S_HOOK_A: begin
        hk_rd_en   = 1'b1;
        state_next = S_HOOK_B;
      end
      S_HOOK_B: begin
        if (op_r == OP_FADE) begin
          hk_rd_en   = 1'b1;
          hk_rd_addr = HW'(tgt_r);
          state_next = S_SETUP;
        end else begin
          state_next = S_CAND;
        end
      end
      S_CAND: begin
        hk_rd_addr = i_r[HW-1:0];
        if (i_r >= cnt_eff) begin
          state_next = S_FINISH;
        end else if (!skip) begin
          hk_rd_en   = 1'b1;
          state_next = S_SETUP;
        end
      end
      S_SETUP: begin
        lctrl.load = 1'b1;
        state_next = S_WALK;
      end
      S_WALK: begin
        pm_rd_en   = 1'b1;
        pm_rd_x    = pos_x;
        pm_rd_y    = pos_y;
        state_next = S_ACC;
      end
      S_ACC: begin
        pm_wr_x    = pos_x;
        pm_wr_y    = pos_y;
        pm_wr_data = faded[PIX_W] ? WHITE : faded[PIX_W-1:0];
        pm_wr_en   = (op_r == OP_FADE) && pm_rd_in;
        if (at_end) begin
          state_next = (op_r == OP_FADE) ? S_FINISH : S_MUL_A;
        end else begin
          lctrl.step = 1'b1;
          state_next = S_WALK;
        end
      end
      S_MUL_A:  state_next = S_MUL_B;
      S_MUL_B:  state_next = S_CMP;
      S_CMP:    state_next = S_CAND;
      S_FINISH: state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (start) begin
          op_r      <= op_t'(opcode);
          x_r       <= coord_x;
          y_r       <= coord_y;
          val_r     <= pixel_value;
          cur_r     <= hook_index;
          tgt_r     <= target_hook;
          i_r       <= '0;
          bsum      <= '0;
          bcnt      <= CNT_W'(1);
          bnext     <= '0;
          got       <= 1'b0;
          cnt_eff   <= (32'(hook_count) > MAX_HOOKS) ? CW'(MAX_HOOKS) : CW'(hook_count);
          upper     <= DW'(min_gap) <= ((32'(hook_count) > MAX_HOOKS) ?
                       DW'(MAX_HOOKS) : DW'(hook_count));
          limit     <= ((32'(hook_count) > MAX_HOOKS) ? DW'(MAX_HOOKS) : DW'(hook_count))
                       - DW'(min_gap);
          res_read  <= '0;
          res_hook  <= '0;
          res_found <= 1'b0;
          res_sum   <= '0;
          res_cnt   <= '0;
        end
      end
      S_REDUCE: begin
        // fold hook indexes into the table, one subtraction a cycle
        if (32'(cur_r) >= MAX_HOOKS) begin
          cur_r <= cur_r - 8'(MAX_HOOKS);
        end else if (32'(tgt_r) >= MAX_HOOKS) begin
          tgt_r <= tgt_r - 8'(MAX_HOOKS);
        end
      end
      S_PIX_RESP: res_read <= pm_rd_in ? pm_rd_data : '0;
      S_HOOK_B: begin
        a_x <= hk_rd[COORD_W-1:0];
        a_y <= hk_rd[2*COORD_W-1:COORD_W];
      end
      S_CAND: begin
        if (i_r >= cnt_eff) begin
          if (got) begin
            res_hook  <= 8'(bnext);
            res_found <= 1'b1;
            res_sum   <= bsum;
            res_cnt   <= bcnt;
          end
        end else if (skip) begin
          i_r <= i_r + 1'b1;
        end
      end
      S_SETUP: begin
        sum_r <= '0;
        n_r   <= '0;
      end
      S_ACC: begin
        n_r <= n_r + 1'b1;
        if (pm_rd_in) begin
          sum_r <= sum_r + SUM_W'(WHITE - pm_rd_data);
        end
      end
      S_MUL_A: prod_a <= mul_p;
      S_MUL_B: prod_b <= mul_p;
      S_CMP: begin
        // strictly better average wins, so ties keep the earlier hook
        if (prod_a > prod_b) begin
          bsum  <= sum_r;
          bcnt  <= n_r;
          bnext <= i_r;
          got   <= 1'b1;
        end
        i_r <= i_r + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (hk_wr_en) begin
      hook_mem[HW'(cur_r)] <= {y_r, x_r};
    end
  end

  always_ff @(posedge clk) begin
    if (hk_rd_en) begin
      hk_rd <= hook_mem[hk_rd_addr];
    end
  end

  sap_pixel_mem #(
    .IMG_SIDE (IMG_SIDE)
  ) u_pix (
    .clk     (clk),
    .rd_en   (pm_rd_en),
    .rd_x    (pm_rd_x),
    .rd_y    (pm_rd_y),
    .wr_en   (pm_wr_en),
    .wr_x    (pm_wr_x),
    .wr_y    (pm_wr_y),
    .wr_data (pm_wr_data),
    .rd_data (pm_rd_data),
    .rd_in   (pm_rd_in)
  );

  sap_line_walk u_walk (
    .clk    (clk),
    .ctrl   (lctrl),
    .a_x    (a_x),
    .a_y    (a_y),
    .b_x    (hk_rd[COORD_W-1:0]),
    .b_y    (hk_rd[2*COORD_W-1:COORD_W]),
    .pos_x  (pos_x),
    .pos_y  (pos_y),
    .at_end (at_end)
  );

  assert property (@(posedge clk) disable iff (rst) done |=> !busy)
    else $error("block still busy after result word");
  assert property (@(posedge clk) disable iff (rst) accept |=> busy && !done)
    else $error("accepted command did not start work");
  assert property (@(posedge clk) disable iff (rst) (done && found) |-> (best_count != '0))
    else $error("picked line has no pixels");
  assert property (@(posedge clk) disable iff (rst)
    (done && !found) |-> (next_hook == '0 && best_sum == '0 && best_count == '0))
    else $error("empty pick returned nonzero fields");

endmodule
`default_nettype wire

// File: src/sap_pixel_mem.sv
`timescale 1ns / 1ps
`default_nettype none
module sap_pixel_mem #(
  parameter int IMG_SIDE = 512
) (
  input  wire logic                         clk,
  input  wire logic                         rd_en,
  input  wire logic [sap_pkg::COORD_W-1:0]  rd_x,
  input  wire logic [sap_pkg::COORD_W-1:0]  rd_y,
  input  wire logic                         wr_en,
  input  wire logic [sap_pkg::COORD_W-1:0]  wr_x,
  input  wire logic [sap_pkg::COORD_W-1:0]  wr_y,
  input  wire logic [sap_pkg::PIX_W-1:0]    wr_data,
  output logic      [sap_pkg::PIX_W-1:0]    rd_data,
  output logic                              rd_in
);
  import sap_pkg::*;

  localparam int DEPTH = IMG_SIDE * IMG_SIDE;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [AW-1:0] SIDE_A = AW'(IMG_SIDE);

  logic [PIX_W-1:0] mem [DEPTH];
  logic [AW-1:0]    rd_addr;
  logic [AW-1:0]    wr_addr;
  logic             rd_in_c;
  logic             wr_in_c;

  assign rd_in_c = (32'(rd_x) < IMG_SIDE) && (32'(rd_y) < IMG_SIDE);
  assign wr_in_c = (32'(wr_x) < IMG_SIDE) && (32'(wr_y) < IMG_SIDE);
  assign rd_addr = AW'(rd_y) * SIDE_A + AW'(rd_x);
  assign wr_addr = AW'(wr_y) * SIDE_A + AW'(wr_x);

  // drop writes that fall outside the image
  always_ff @(posedge clk) begin
    if (wr_en && wr_in_c) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
      rd_in   <= rd_in_c;
    end
  end

endmodule
`default_nettype wire

// File: src/sap_line_walk.sv
`timescale 1ns / 1ps
`default_nettype none
module sap_line_walk (
  input  wire logic                         clk,
  input  wire sap_pkg::line_ctrl_t          ctrl,
  input  wire logic [sap_pkg::COORD_W-1:0]  a_x,
  input  wire logic [sap_pkg::COORD_W-1:0]  a_y,
  input  wire logic [sap_pkg::COORD_W-1:0]  b_x,
  input  wire logic [sap_pkg::COORD_W-1:0]  b_y,
  output logic      [sap_pkg::COORD_W-1:0]  pos_x,
  output logic      [sap_pkg::COORD_W-1:0]  pos_y,
  output logic                              at_end
);
  import sap_pkg::*;

  logic [COORD_W-1:0] end_x;
  logic [COORD_W-1:0] end_y;
  logic signed [10:0] dx;
  logic signed [10:0] dy;
  logic               sx_neg;
  logic               sy_neg;
  logic signed [11:0] err;

  logic [COORD_W-1:0] adx;
  logic [COORD_W-1:0] ady;
  logic signed [12:0] e2;
  logic               step_x;
  logic               step_y;
  logic signed [11:0] err_next;

  assign adx = (b_x > a_x) ? b_x - a_x : a_x - b_x;
  assign ady = (b_y > a_y) ? b_y - a_y : a_y - b_y;

  assign e2       = {err, 1'b0};
  assign step_x   = e2 > 13'(dy);
  assign step_y   = e2 < 13'(dx);
  assign err_next = err + (step_x ? 12'(dy) : 12'sd0) + (step_y ? 12'(dx) : 12'sd0);
  assign at_end   = (pos_x == end_x) && (pos_y == end_y);

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      pos_x  <= a_x;
      pos_y  <= a_y;
      end_x  <= b_x;
      end_y  <= b_y;
      dx     <= signed'({2'b00, adx});
      dy     <= -signed'({2'b00, ady});
      sx_neg <= !(a_x < b_x);
      sy_neg <= !(a_y < b_y);
      err    <= signed'({3'b000, adx}) - signed'({3'b000, ady});
    end else if (ctrl.step) begin
      err <= err_next;
      if (step_x) begin
        pos_x <= sx_neg ? pos_x - 1'b1 : pos_x + 1'b1;
      end
      if (step_y) begin
        pos_y <= sy_neg ? pos_y - 1'b1 : pos_y + 1'b1;
      end
    end
  end

endmodule
`default_nettype wire
